// File: rtl/itt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed timer table.
// Holds field layouts, item kind codes and the control/status structs.
// No dependencies.
package itt_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;
	localparam int MAX_RESULTS    = 16;
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int DELAY_W = 24;
	localparam int TAG_W   = 32;
	localparam int NOW_W   = 32;

	localparam int IN_KIND_LSB  = 0;
	localparam int IN_SLOT_LSB  = IN_KIND_LSB + KIND_W;
	localparam int IN_DELAY_LSB = IN_SLOT_LSB + SLOT_W;
	localparam int IN_PER_LSB   = IN_DELAY_LSB + DELAY_W;
	localparam int IN_TAG_LSB   = IN_PER_LSB + 1;
	localparam int IN_NOW_LSB   = IN_TAG_LSB + TAG_W;
	localparam int IN_DATA_W    = 96;

	localparam int OUT_SLOT_LSB = 0;
	localparam int OUT_TAG_LSB  = OUT_SLOT_LSB + SLOT_W;
	localparam int OUT_PAD_W    = 4;
	localparam int OUT_DATA_W   = SLOT_W + TAG_W + OUT_PAD_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} itt_cmd_t;

	typedef struct packed {
		logic hit;
		logic held_valid;
		logic out_free;
		logic scan_end;
	} itt_sts_t;

endpackage

// File: rtl/itt_ctrl.sv
`timescale 1ns / 1ps
// Controller of the indexed timer table: idle, slot scan and final flush.
// Depends on itt_pkg for the command and status structs.
module itt_ctrl
	import itt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  kind_t    in_kind,
	output logic     in_ready,
	input  itt_sts_t sts,
	output itt_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_kind == KIND_TICK) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.step = !(sts.hit && sts.held_valid && !sts.out_free);
				if (cmd.step && sts.scan_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.held_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.held_valid)
		else $error("result held while controller is idle");

	a_flush_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (sts.held_valid && sts.out_free))
		else $error("flush issued without a held result or output room");

	a_stall_keeps_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.hit && sts.held_valid && !sts.out_free)
		|=> (state_q == ST_SCAN))
		else $error("scan left while a firing slot was stalled");

endmodule

// File: rtl/itt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the indexed timer table: slot memory, armed bits, scan index,
// held result and output register. Depends on itt_pkg.
module itt_datapath
	import itt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  itt_cmd_t                 cmd,
	output itt_sts_t                 sts,
	input  kind_t                    in_kind,
	input  logic [SLOT_W-1:0]        in_slot,
	input  logic [DELAY_W-1:0]       in_delay,
	input  logic                     in_periodic,
	input  logic signed [TAG_W-1:0]  in_tag,
	input  logic [NOW_W-1:0]         in_now,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SLOT_W-1:0]        out_slot,
	output logic signed [TAG_W-1:0]  out_tag,
	output logic                     out_last
);

	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int SUM_W      = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
	localparam int E_DL       = 0;
	localparam int E_PER      = TIME_BITS;
	localparam int E_REP      = E_PER + DELAY_W;
	localparam int E_TAG      = E_REP + 1;
	localparam int ENT_W      = E_TAG + TAG_W;
	localparam int SLOT_EXT_W = 7;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] base,
		input logic [DELAY_W-1:0]   delta
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(delta);
		if (sum[SUM_W-1:TIME_BITS] != '0) begin
			return '1;
		end
		return sum[TIME_BITS-1:0];
	endfunction

	logic [ENT_W-1:0]      mem_q [SLOT_COUNT];
	logic [ENT_W-1:0]      rdata_q;
	logic [SLOT_COUNT-1:0] armed_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_BITS-1:0]  now_q;
	logic                  held_valid_q;
	logic [SLOT_W-1:0]     held_slot_q;
	logic [TAG_W-1:0]      held_tag_q;
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [TAG_W-1:0]      out_tag_q;
	logic                  out_last_q;

	logic [63:0]           now64;
	logic [TIME_BITS-1:0]  now_in;
	logic [SLOT_EXT_W-1:0] slot_ext;
	logic [SLOT_EXT_W-1:0] idx_ext;
	logic                  slot_ok;
	logic [IDX_W-1:0]      wr_slot;
	logic [TIME_BITS-1:0]  rd_dl;
	logic [DELAY_W-1:0]    rd_per;
	logic                  rd_rep;
	logic [TAG_W-1:0]      rd_tag;
	logic                  hit;
	logic                  take;
	logic                  out_free;
	logic                  scan_end;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [ENT_W-1:0]      wdata;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      idx_next;

	assign now64    = 64'(in_now);
	assign now_in   = now64[TIME_BITS-1:0];
	assign slot_ext = SLOT_EXT_W'(in_slot);
	assign slot_ok  = slot_ext < SLOT_EXT_W'(SLOT_COUNT);
	assign wr_slot  = slot_ext[IDX_W-1:0];
	assign idx_ext  = SLOT_EXT_W'(idx_q);

	assign rd_dl  = rdata_q[E_DL +: TIME_BITS];
	assign rd_per = rdata_q[E_PER +: DELAY_W];
	assign rd_rep = rdata_q[E_REP];
	assign rd_tag = rdata_q[E_TAG +: TAG_W];

	assign hit      = armed_q[idx_q] && (now_q >= rd_dl) && (cnt_q < CNT_W'(MAX_RESULTS));
	assign take     = cmd.step && hit;
	assign out_free = !out_valid_q || out_ready;
	assign scan_end = idx_q == LAST_IDX;
	assign idx_next = scan_end ? '0 : idx_q + 1'b1;
	assign rd_addr  = cmd.step ? idx_next : idx_q;

	assign sts.hit        = hit;
	assign sts.held_valid = held_valid_q;
	assign sts.out_free   = out_free;
	assign sts.scan_end   = scan_end;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		if (cmd.load && in_kind == KIND_CREATE && slot_ok) begin
			we    = 1'b1;
			waddr = wr_slot;
			wdata = {in_tag, in_periodic, in_delay, sat_add(now_in, in_delay)};
		end else if (take && rd_rep) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = {rdata_q[ENT_W-1:TIME_BITS], sat_add(now_q, rd_per)};
		end
	end

	// Slot fields are only read while the slot is armed, so they need no reset.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				cnt_q <= '0;
				case (in_kind)
					KIND_CREATE: begin
						if (slot_ok) begin
							armed_q[wr_slot] <= 1'b1;
						end
					end
					KIND_REMOVE: begin
						if (slot_ok) begin
							armed_q[wr_slot] <= 1'b0;
						end
					end
					KIND_CLEAR: begin
						armed_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.step) begin
				idx_q <= idx_next;
			end
			if (take) begin
				cnt_q        <= cnt_q + 1'b1;
				held_valid_q <= 1'b1;
				if (!rd_rep) begin
					armed_q[idx_q] <= 1'b0;
				end
			end else if (cmd.flush) begin
				held_valid_q <= 1'b0;
			end
			if ((take && held_valid_q) || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_in;
		end
		if (take) begin
			held_slot_q <= idx_ext[SLOT_W-1:0];
			held_tag_q  <= rd_tag;
		end
		if ((take && held_valid_q) || cmd.flush) begin
			out_slot_q <= held_slot_q;
			out_tag_q  <= held_tag_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_slot  = out_slot_q;
	assign out_tag   = out_tag_q;
	assign out_last  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("fire count above the per-tick limit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("scan index beyond the last slot");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(take && held_valid_q) |-> out_free)
		else $error("held result pushed into a full output register");

endmodule

// File: rtl/indexed_timer_table.sv
`timescale 1ns / 1ps
// Top level of the indexed timer table: stream ports, controller and datapath.
// Depends on itt_pkg, itt_ctrl and itt_datapath.
//
// Channel | Dir | Signals                            | Contents
// s       | in  | s_tvalid s_tready s_tdata[95:0]    | command item
// m       | out | m_tvalid m_tready m_tdata[39:0]    | fired timer item, m_tlast on final
//
// Create, remove and clear items are each accepted in the idle state, which the controller does not leave for them.
// A tick item scans one slot per cycle, unless the scan is stalled, through the
// single read port of the slot memory; a flush state then releases the last result.
// A scan waits while a second firing slot finds the output register still full.
// Reset clears the armed bits at once; no clearing pass follows reset.
module indexed_timer_table
	import itt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// kind[1:0], slot[5:2], delay_ms[29:6], periodic[30], tag[62:31],
	// now_ms[94:63], zero[95].
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fired_slot[3:0], fired_tag[35:4], zero[39:36].
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	itt_cmd_t                cmd;
	itt_sts_t                sts;
	kind_t                   in_kind;
	logic [SLOT_W-1:0]       out_slot;
	logic signed [TAG_W-1:0] out_tag;

	assign in_kind = kind_t'(s_tdata[IN_KIND_LSB +: KIND_W]);

	itt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (in_kind),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itt_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.TIME_BITS  (TIME_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_kind     (in_kind),
		.in_slot     (s_tdata[IN_SLOT_LSB +: SLOT_W]),
		.in_delay    (s_tdata[IN_DELAY_LSB +: DELAY_W]),
		.in_periodic (s_tdata[IN_PER_LSB]),
		.in_tag      (s_tdata[IN_TAG_LSB +: TAG_W]),
		.in_now      (s_tdata[IN_NOW_LSB +: NOW_W]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_slot    (out_slot),
		.out_tag     (out_tag),
		.out_last    (m_tlast)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_tag, out_slot};

endmodule
